// File: hw/rtl/mmul_pkg.sv
// ----------------------------------------------------------------------------
// mmul_pkg - shared types and constants for the 4x4 matrix multiplier
// Field widths, Q16.16 saturation limits, sequencer states, MAC control.
// ----------------------------------------------------------------------------
`default_nettype none

package mmul_pkg;

  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int POS_W  = 4;
  localparam int DATA_W = 32;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [0:0] {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // One issued MAC step
  typedef struct packed {
    logic vld;        // step is live
    logic first;      // k == 0, restart the sum
    logic lastk;      // k == DIM-1, sum complete after this step
    logic last_elem;  // final element of the product
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mmul_if.sv
// ----------------------------------------------------------------------------
// mmul_if - valid/ready channels of the matrix multiplier
// Input channel carries element pairs, output channel carries product terms.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmul_in_if;
  logic                                valid;
  logic                                ready;
  logic [mmul_pkg::POS_W-1:0]          position;
  logic signed [mmul_pkg::DATA_W-1:0]  left_value;
  logic signed [mmul_pkg::DATA_W-1:0]  right_value;
  logic                                last;

  modport source (output valid, position, left_value, right_value, last, input ready);
  modport sink   (input valid, position, left_value, right_value, last, output ready);
endinterface

interface mmul_out_if;
  logic                                valid;
  logic                                ready;
  logic [mmul_pkg::POS_W-1:0]          out_position;
  logic signed [mmul_pkg::DATA_W-1:0]  product_value;
  logic                                saturated;
  logic                                out_last;

  modport source (output valid, out_position, product_value, saturated, out_last,
                  input ready);
  modport sink   (input valid, out_position, product_value, saturated, out_last,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mmul_store.sv
// ----------------------------------------------------------------------------
// mmul_store - left and right element memories
// One write port shared by both, one registered read port each. Per-entry
// valid flags make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mmul_store #(
  parameter int DIM = mmul_pkg::DIM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(DIM*DIM)-1:0]         wr_addr,
  input  wire logic [mmul_pkg::DATA_W-1:0]        wr_left,
  input  wire logic [mmul_pkg::DATA_W-1:0]        wr_right,
  input  wire logic                               rd_en,
  input  wire logic [$clog2(DIM*DIM)-1:0]         rd_left_addr,
  input  wire logic [$clog2(DIM*DIM)-1:0]         rd_right_addr,
  output logic signed [mmul_pkg::DATA_W-1:0]      rd_left,
  output logic signed [mmul_pkg::DATA_W-1:0]      rd_right
);

  localparam int DEPTH = DIM * DIM;

  logic [mmul_pkg::DATA_W-1:0] left_mem  [DEPTH];
  logic [mmul_pkg::DATA_W-1:0] right_mem [DEPTH];
  logic [DEPTH-1:0]            ent_vld_r;

  logic [mmul_pkg::DATA_W-1:0] left_rd_r, right_rd_r;
  logic                        left_vld_r, right_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_left;
      right_mem[wr_addr] <= wr_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      left_rd_r   <= left_mem[rd_left_addr];
      right_rd_r  <= right_mem[rd_right_addr];
      left_vld_r  <= ent_vld_r[rd_left_addr];
      right_vld_r <= ent_vld_r[rd_right_addr];
    end
  end

  assign rd_left  = left_vld_r  ? left_rd_r  : '0;
  assign rd_right = right_vld_r ? right_rd_r : '0;

endmodule

`default_nettype wire

// File: hw/rtl/mmul_seq.sv
// ----------------------------------------------------------------------------
// mmul_seq - MAC step sequencer
// Walks row, column and k for every product element, one step per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module mmul_seq #(
  parameter int DIM = mmul_pkg::DIM_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         adv,
  output logic                              in_ready,
  output mmul_pkg::mac_ctl_t                iss_ctl,
  output logic [$clog2(DIM*DIM)-1:0]        iss_idx,
  output logic [$clog2(DIM*DIM)-1:0]        left_addr,
  output logic [$clog2(DIM*DIM)-1:0]        right_addr
);

  localparam int AW = $clog2(DIM*DIM);
  localparam int KW = $clog2(DIM);
  localparam logic [KW-1:0] K_MAX = KW'(DIM - 1);

  mmul_pkg::seq_state_t state_r, state_nxt;
  logic [KW-1:0] row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  logic          final_step;

  assign final_step = (row_r == K_MAX) && (col_r == K_MAX) && (k_r == K_MAX);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmul_pkg::SEQ_IDLE: if (start) state_nxt = mmul_pkg::SEQ_RUN;
      mmul_pkg::SEQ_RUN:  if (adv && final_step) state_nxt = mmul_pkg::SEQ_IDLE;
      default:            state_nxt = mmul_pkg::SEQ_IDLE;
    endcase
  end

  // Counters wrap back to zero after the final step
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    k_nxt   = k_r;
    if (state_r == mmul_pkg::SEQ_RUN && adv) begin
      if (k_r == K_MAX) begin
        k_nxt = '0;
        if (col_r == K_MAX) begin
          col_nxt = '0;
          row_nxt = (row_r == K_MAX) ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmul_pkg::SEQ_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_ready          = (state_r == mmul_pkg::SEQ_IDLE);
    iss_ctl.vld       = (state_r == mmul_pkg::SEQ_RUN);
    iss_ctl.first     = (k_r == '0);
    iss_ctl.lastk     = (k_r == K_MAX);
    iss_ctl.last_elem = (row_r == K_MAX) && (col_r == K_MAX);
    iss_idx    = AW'(row_r) * AW'(DIM) + AW'(col_r);
    left_addr  = AW'(row_r) * AW'(DIM) + AW'(k_r);
    right_addr = AW'(k_r) * AW'(DIM) + AW'(col_r);
  end

endmodule

`default_nettype wire

// File: hw/rtl/mmul_mac.sv
// ----------------------------------------------------------------------------
// mmul_mac - shared multiply-accumulate unit with output register
// Multiply, exact accumulate, arithmetic shift and saturate to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module mmul_mac #(
  parameter int DIM       = mmul_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mmul_pkg::mac_ctl_t                 iss_ctl,
  input  wire logic [$clog2(DIM*DIM)-1:0]         iss_idx,
  input  wire logic signed [mmul_pkg::DATA_W-1:0] rd_left,
  input  wire logic signed [mmul_pkg::DATA_W-1:0] rd_right,
  input  wire logic                               out_ready,
  output logic                                    adv,
  output logic                                    out_valid,
  output logic [mmul_pkg::POS_W-1:0]              out_position,
  output logic signed [mmul_pkg::DATA_W-1:0]      product_value,
  output logic                                    saturated,
  output logic                                    out_last
);

  localparam int AW    = $clog2(DIM*DIM);
  localparam int DW    = mmul_pkg::DATA_W;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + $clog2(DIM);
  localparam int HI_W  = ACC_W - DW + 1;

  mmul_pkg::mac_ctl_t s1_ctl_r, s2_ctl_r;
  logic [AW-1:0]      s1_idx_r, s2_idx_r, acc_idx_r;
  logic               acc_last_r, acc_done_r;

  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] prod_ext, acc_r, acc_nxt, shifted;
  logic [HI_W-1:0]         hi_bits;
  logic                    sat;
  logic [DW-1:0]           sat_val;

  logic                    out_valid_r;
  logic [mmul_pkg::POS_W-1:0] out_pos_r;
  logic [DW-1:0]           out_val_r;
  logic                    out_sat_r, out_last_r;

  // Whole pipe holds while a finished term is refused downstream
  assign adv = !out_valid_r || out_ready;

  assign prod_ext = {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
  assign acc_nxt  = s2_ctl_r.first ? prod_ext : acc_r + prod_ext;

  assign shifted = acc_r >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:DW-1];
  assign sat     = !((&hi_bits) || !(|hi_bits));
  assign sat_val = sat ? (shifted[ACC_W-1] ? mmul_pkg::Q_MIN : mmul_pkg::Q_MAX)
                       : shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r    <= '0;
      s2_ctl_r    <= '0;
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_ctl_r    <= iss_ctl;
      s2_ctl_r    <= s1_ctl_r;
      acc_done_r  <= s2_ctl_r.vld && s2_ctl_r.lastk;
      out_valid_r <= acc_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r <= iss_idx;
      s2_idx_r <= s1_idx_r;
      prod_r   <= rd_left * rd_right;
      if (s2_ctl_r.vld) begin
        acc_r      <= acc_nxt;
        acc_idx_r  <= s2_idx_r;
        acc_last_r <= s2_ctl_r.last_elem;
      end
      if (acc_done_r) begin
        out_pos_r  <= mmul_pkg::POS_W'(acc_idx_r);
        out_val_r  <= sat_val;
        out_sat_r  <= sat;
        out_last_r <= acc_last_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_position  = out_pos_r;
  assign product_value = out_val_r;
  assign saturated     = out_sat_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/matrix4x4_multiply_top.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply_top - DIM x DIM signed Q16.16 matrix multiplier
// Flow: an item without last is only stored; after an item with last, the
//   product terms follow.
// Throughput: set by the single shared multiply-accumulate unit (one MAC per
//   cycle while the output register is not held by a refused term).
// Reset: rst_n synchronous, active low; both element stores then read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure
//   mmul_store : left/right element memories, registered read, per-entry valid
//                flags so that entries never written since reset read as zero
//                (no clearing pass is needed).
//   mmul_seq   : sequencer; in IDLE it takes element pairs, an item with last
//                starts RUN, stepping (row, col, k) one MAC per unstalled cycle.
//   mmul_mac   : read -> multiply -> accumulate -> shift/saturate -> output
//                register. The whole pipe advances together and holds only
//                while the output register is full and not taken.
//
// Input channel is ready only in IDLE. Once the last MAC step is issued the
// sequencer returns to IDLE and new pairs can be stored while the tail of the
// previous product still drains; stored reads are all done by then, so the
// new writes cannot disturb it.
//
// A position at or beyond DIM*DIM stores nothing, but last still triggers.
// Output position is the low four bits of the row-major index.

module matrix4x4_multiply_top #(
  parameter int DIM       = mmul_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mmul_in_if.sink    in_ch,
  mmul_out_if.source out_ch
);

  localparam int AW    = $clog2(DIM*DIM);
  localparam int DEPTH = DIM * DIM;

  logic               in_xfer;     // input transfer this cycle
  logic               wr_en;
  logic               adv;
  mmul_pkg::mac_ctl_t iss_ctl;
  logic [AW-1:0]      iss_idx, left_addr, right_addr;
  logic signed [mmul_pkg::DATA_W-1:0] rd_left, rd_right;

  assign in_xfer = in_ch.valid && in_ch.ready;
  // Positions outside the matrix are dropped
  assign wr_en   = in_xfer && (32'(in_ch.position) < 32'(DEPTH));

  mmul_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_xfer && in_ch.last),
    .adv        (adv),
    .in_ready   (in_ch.ready),
    .iss_ctl    (iss_ctl),
    .iss_idx    (iss_idx),
    .left_addr  (left_addr),
    .right_addr (right_addr)
  );

  mmul_store #(
    .DIM (DIM)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (wr_en),
    .wr_addr       (AW'(in_ch.position)),
    .wr_left       (in_ch.left_value),
    .wr_right      (in_ch.right_value),
    .rd_en         (adv),
    .rd_left_addr  (left_addr),
    .rd_right_addr (right_addr),
    .rd_left       (rd_left),
    .rd_right      (rd_right)
  );

  mmul_mac #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .iss_ctl       (iss_ctl),
    .iss_idx       (iss_idx),
    .rd_left       (rd_left),
    .rd_right      (rd_right),
    .out_ready     (out_ch.ready),
    .adv           (adv),
    .out_valid     (out_ch.valid),
    .out_position  (out_ch.out_position),
    .product_value (out_ch.product_value),
    .saturated     (out_ch.saturated),
    .out_last      (out_ch.out_last)
  );

endmodule

`default_nettype wire
